FILE: sv/bsbc_pkg.sv
// bsbc_pkg: shared types and constants for the box-center bounding sphere block
// no dependencies
`default_nettype none
package bsbc_pkg;
    localparam int unsigned COORD_W = 24;
    localparam int unsigned RAD_W   = 25;
    localparam int unsigned DSQ_W   = 51;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t cx;
        coord_t cy;
        coord_t cz;
        logic   dropped;
    } job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_SQRT,
        ST_OUT
    } back_state_t;
endpackage
`default_nettype wire

FILE: sv/bounding_sphere_from_box_center.sv
// bounding_sphere_from_box_center: top level, front end, job queue, back end, vertex store
// uses bsbc_pkg, bsbc_front, bsbc_queue, bsbc_back
//
// Takes one vertex per cycle into a store of MAX_VERTICES entries while tracking the
// box bounds; the transfer carrying last_vertex closes the set. The back end then
// reads every stored vertex once (one per cycle, single read port), keeps the largest
// squared distance to the box center, and runs a 26-step bit-serial square root on it.
// Input stalls from the closing transfer until the back end has finished the set, and
// a further closed set waits in the queue while a result is held on the output.
`default_nettype none
module bounding_sphere_from_box_center #(
    parameter int unsigned MAX_VERTICES = 4096
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_stall,
    input  bsbc_pkg::coord_t    vert_x,
    input  bsbc_pkg::coord_t    vert_y,
    input  bsbc_pkg::coord_t    vert_z,
    input  wire                 last_vertex,
    output logic                out_valid,
    input  wire                 out_stall,
    output bsbc_pkg::coord_t    center_x,
    output bsbc_pkg::coord_t    center_y,
    output bsbc_pkg::coord_t    center_z,
    output logic [bsbc_pkg::RAD_W-1:0] radius,
    output logic                overflowed
);
    import bsbc_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int unsigned AW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

    logic job_full, job_push, job_pop, store_busy, wr_en, rd_en;
    job_t job_in, job_head;
    logic [CNT_W-1:0] cnt_in, cnt_head, wr_addr;
    logic [AW-1:0] rd_addr;
    coord_t wr_x, wr_y, wr_z;
    coord_t rd_x_reg, rd_y_reg, rd_z_reg;
    coord_t mem_x [MAX_VERTICES];
    coord_t mem_y [MAX_VERTICES];
    coord_t mem_z [MAX_VERTICES];

    bsbc_front #(.CNT_W(CNT_W)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .vert_x(vert_x), .vert_y(vert_y), .vert_z(vert_z), .last_vertex(last_vertex),
        .max_count(CNT_W'(MAX_VERTICES)), .job_full(job_full), .job_push(job_push),
        .job(job_in), .job_count(cnt_in), .store_busy(store_busy || job_full),
        .wr_en(wr_en), .wr_addr(wr_addr), .wr_x(wr_x), .wr_y(wr_y), .wr_z(wr_z)
    );

    bsbc_queue #(.CNT_W(CNT_W)) u_queue (
        .clk(clk), .rst_n(rst_n), .push(job_push), .push_job(job_in),
        .push_count(cnt_in), .full(job_full), .pop(job_pop),
        .head_job(job_head), .head_count(cnt_head)
    );

    bsbc_back #(.CNT_W(CNT_W), .AW(AW)) u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(job_full), .job(job_head),
        .job_count(cnt_head), .job_pop(job_pop), .store_busy(store_busy),
        .rd_en(rd_en), .rd_addr(rd_addr), .rd_x(rd_x_reg), .rd_y(rd_y_reg),
        .rd_z(rd_z_reg), .out_valid(out_valid), .out_stall(out_stall),
        .center_x(center_x), .center_y(center_y), .center_z(center_z),
        .radius(radius), .overflowed(overflowed)
    );

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_x[wr_addr[AW-1:0]] <= wr_x;
            mem_y[wr_addr[AW-1:0]] <= wr_y;
            mem_z[wr_addr[AW-1:0]] <= wr_z;
        end
        if (rd_en)
        begin
            rd_x_reg <= mem_x[rd_addr];
            rd_y_reg <= mem_y[rd_addr];
            rd_z_reg <= mem_z[rd_addr];
        end
    end
endmodule
`default_nettype wire

FILE: sv/bsbc_front.sv
// bsbc_front: accepts vertices, writes them to the store, tracks the box bounds
// on the last vertex pushes the center and drop flag as a job; uses bsbc_pkg
`default_nettype none
module bsbc_front #(
    parameter int unsigned CNT_W = 13
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_stall,
    input  bsbc_pkg::coord_t    vert_x,
    input  bsbc_pkg::coord_t    vert_y,
    input  bsbc_pkg::coord_t    vert_z,
    input  wire                 last_vertex,
    input  wire  [CNT_W-1:0]    max_count,
    input  wire                 job_full,
    output logic                job_push,
    output bsbc_pkg::job_t      job,
    output logic [CNT_W-1:0]    job_count,
    input  wire                 store_busy,
    output logic                wr_en,
    output logic [CNT_W-1:0]    wr_addr,
    output bsbc_pkg::coord_t    wr_x,
    output bsbc_pkg::coord_t    wr_y,
    output bsbc_pkg::coord_t    wr_z
);
    import bsbc_pkg::*;

    localparam coord_t CMAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam coord_t CMIN = {1'b1, {(COORD_W-1){1'b0}}};

    coord_t lo_x_reg, lo_y_reg, lo_z_reg, hi_x_reg, hi_y_reg, hi_z_reg;
    coord_t lo_x_next, lo_y_next, lo_z_next, hi_x_next, hi_y_next, hi_z_next;
    logic [CNT_W-1:0] count_reg;
    logic drop_reg;
    logic acc, room;

    function automatic coord_t mid(input coord_t a, input coord_t b);
        logic signed [COORD_W:0] s;
        s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
        return s[COORD_W:1];
    endfunction

    // input waits while a job is queued or the back end is busy
    assign in_stall = job_full || store_busy;
    assign acc      = in_valid && !in_stall;
    assign room     = count_reg != max_count;

    assign wr_en   = acc && room;
    assign wr_addr = count_reg;
    assign wr_x    = vert_x;
    assign wr_y    = vert_y;
    assign wr_z    = vert_z;

    always_comb
    begin
        lo_x_next = lo_x_reg; lo_y_next = lo_y_reg; lo_z_next = lo_z_reg;
        hi_x_next = hi_x_reg; hi_y_next = hi_y_reg; hi_z_next = hi_z_reg;
        if (room)
        begin
            if (vert_x < lo_x_reg) lo_x_next = vert_x;
            if (vert_y < lo_y_reg) lo_y_next = vert_y;
            if (vert_z < lo_z_reg) lo_z_next = vert_z;
            if (vert_x > hi_x_reg) hi_x_next = vert_x;
            if (vert_y > hi_y_reg) hi_y_next = vert_y;
            if (vert_z > hi_z_reg) hi_z_next = vert_z;
        end
    end

    assign job_push    = acc && last_vertex;
    assign job.cx      = mid(lo_x_next, hi_x_next);
    assign job.cy      = mid(lo_y_next, hi_y_next);
    assign job.cz      = mid(lo_z_next, hi_z_next);
    assign job.dropped = drop_reg || !room;
    assign job_count   = room ? count_reg + CNT_W'(1) : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_x_reg <= CMAX; lo_y_reg <= CMAX; lo_z_reg <= CMAX;
            hi_x_reg <= CMIN; hi_y_reg <= CMIN; hi_z_reg <= CMIN;
            count_reg <= '0;
            drop_reg  <= 1'b0;
        end
        else if (acc)
        begin
            if (last_vertex)
            begin
                lo_x_reg <= CMAX; lo_y_reg <= CMAX; lo_z_reg <= CMAX;
                hi_x_reg <= CMIN; hi_y_reg <= CMIN; hi_z_reg <= CMIN;
                count_reg <= '0;
                drop_reg  <= 1'b0;
            end
            else
            begin
                lo_x_reg <= lo_x_next; lo_y_reg <= lo_y_next; lo_z_reg <= lo_z_next;
                hi_x_reg <= hi_x_next; hi_y_reg <= hi_y_next; hi_z_reg <= hi_z_next;
                count_reg <= job_count;
                drop_reg  <= drop_reg || !room;
            end
        end
    end
endmodule
`default_nettype wire

FILE: sv/bsbc_queue.sv
// bsbc_queue: one-entry job register between front and back
// uses bsbc_pkg
`default_nettype none
module bsbc_queue #(
    parameter int unsigned CNT_W = 13
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               push,
    input  bsbc_pkg::job_t    push_job,
    input  wire  [CNT_W-1:0]  push_count,
    output logic              full,
    input  wire               pop,
    output bsbc_pkg::job_t    head_job,
    output logic [CNT_W-1:0]  head_count
);
    import bsbc_pkg::*;

    logic full_reg;
    job_t job_reg;
    logic [CNT_W-1:0] count_reg;

    assign full       = full_reg;
    assign head_job   = job_reg;
    assign head_count = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            full_reg <= 1'b0;
        else if (push)
            full_reg <= 1'b1;
        else if (pop)
            full_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            job_reg   <= push_job;
            count_reg <= push_count;
        end
    end
endmodule
`default_nettype wire

FILE: sv/bsbc_back.sv
// bsbc_back: distance pass over the store, bit-serial square root, result register
// uses bsbc_pkg
`default_nettype none
module bsbc_back #(
    parameter int unsigned CNT_W = 13,
    parameter int unsigned AW    = 12
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               job_valid,
    input  bsbc_pkg::job_t    job,
    input  wire  [CNT_W-1:0]  job_count,
    output logic              job_pop,
    output logic              store_busy,
    output logic              rd_en,
    output logic [AW-1:0]     rd_addr,
    input  bsbc_pkg::coord_t  rd_x,
    input  bsbc_pkg::coord_t  rd_y,
    input  bsbc_pkg::coord_t  rd_z,
    output logic              out_valid,
    input  wire               out_stall,
    output bsbc_pkg::coord_t  center_x,
    output bsbc_pkg::coord_t  center_y,
    output bsbc_pkg::coord_t  center_z,
    output logic [bsbc_pkg::RAD_W-1:0] radius,
    output logic              overflowed
);
    import bsbc_pkg::*;

    localparam int unsigned DW  = COORD_W + 1;
    localparam int unsigned SQW = 2 * DW;
    localparam int unsigned SQ_STEPS = DSQ_W / 2 + 1;

    back_state_t state_reg, state_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [2:0] vld_reg;
    logic [DW-2:0] ax_reg, ay_reg, az_reg;
    logic [SQW-1:0] sx_reg, sy_reg, sz_reg;
    logic [DSQ_W-1:0] best_reg, sum;
    logic [DSQ_W+1:0] rem_reg, trial;
    logic [RAD_W:0] root_reg;
    logic [DSQ_W:0] val_reg;
    logic [4:0] step_reg;
    logic out_valid_reg;
    coord_t cx_reg, cy_reg, cz_reg;
    logic ovf_reg;

    function automatic logic [DW-2:0] absd(input coord_t a, input coord_t c);
        logic signed [DW-1:0] d;
        d = {a[COORD_W-1], a} - {c[COORD_W-1], c};
        return d[DW-1] ? (DW-1)'(-d) : d[DW-2:0];
    endfunction

    assign sum = DSQ_W'(sx_reg) + DSQ_W'(sy_reg) + DSQ_W'(sz_reg);
    assign trial = {rem_reg[DSQ_W-1:0], val_reg[DSQ_W:DSQ_W-1]}
                 - {root_reg[RAD_W-1:0], 2'b01};

    assign store_busy = state_reg != ST_IDLE;
    assign rd_en      = state_reg == ST_SCAN;
    assign rd_addr    = idx_reg[AW-1:0];
    assign job_pop    = state_reg == ST_OUT && !out_valid_reg;
    assign out_valid  = out_valid_reg;
    assign center_x   = cx_reg;
    assign center_y   = cy_reg;
    assign center_z   = cz_reg;
    assign overflowed = ovf_reg;
    assign radius     = root_reg[RAD_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE:
                if (job_valid && !out_valid_reg)
                begin
                    state_next = ST_SCAN;
                    idx_next   = '0;
                end
            ST_SCAN:
            begin
                idx_next = idx_reg + CNT_W'(1);
                if (idx_next == job_count)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
                if (vld_reg == 3'b000)
                    state_next = ST_SQRT;
            ST_SQRT:
                if (step_reg == 5'(SQ_STEPS - 1))
                    state_next = ST_OUT;
            ST_OUT:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            vld_reg   <= {vld_reg[1:0], rd_en};
            if (state_reg == ST_OUT)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // read data is registered after the address, then abs, then square, then sum/compare
    always_ff @(posedge clk)
    begin
        ax_reg <= absd(rd_x, job.cx);
        ay_reg <= absd(rd_y, job.cy);
        az_reg <= absd(rd_z, job.cz);
        sx_reg <= ax_reg * ax_reg;
        sy_reg <= ay_reg * ay_reg;
        sz_reg <= az_reg * az_reg;
        if (state_reg == ST_IDLE)
            best_reg <= '0;
        else if (vld_reg[2] && sum > best_reg)
            best_reg <= sum;
        if (state_reg == ST_OUT)
        begin
            cx_reg  <= job.cx;
            cy_reg  <= job.cy;
            cz_reg  <= job.cz;
            ovf_reg <= job.dropped;
        end
        if (state_reg == ST_DRAIN)
        begin
            rem_reg  <= '0;
            root_reg <= '0;
            val_reg  <= {1'b0, best_reg};
            step_reg <= '0;
        end
        else if (state_reg == ST_SQRT)
        begin
            step_reg <= step_reg + 5'd1;
            val_reg  <= {val_reg[DSQ_W-2:0], 2'b00};
            if (!trial[DSQ_W+1])
            begin
                rem_reg  <= trial;
                root_reg <= {root_reg[RAD_W-1:0], 1'b1};
            end
            else
            begin
                rem_reg  <= {rem_reg[DSQ_W-1:0], val_reg[DSQ_W:DSQ_W-1]};
                root_reg <= {root_reg[RAD_W-1:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire
